[hw/rtl/svdc_pkg.sv]
// package for the signed varint delta coordinate decoder
// holds status codes, decoder constants and the structs passed between stages
`timescale 1ns / 1ps

package svdc_pkg;

    localparam int unsigned MAX_BYTES   = 10;
    localparam logic [3:0]  LAST_BYTE   = 4'(MAX_BYTES - 1);
    localparam logic [1:0]  OPP_SINGLE  = 2'd1;
    localparam logic [1:0]  OPP_RESET   = 2'd2;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_VARINT  = 2'd1,
        ST_SUM_OVF     = 2'd2
    } t_status;

    // outcome of one byte in the varint decoder
    typedef struct packed {
        logic        done;
        logic        bad;
        logic        neg;
        logic [62:0] mag;
    } t_vint_res;

    // one result of the accumulate stage
    typedef struct packed {
        logic               valid;
        logic signed [63:0] first_value;
        logic signed [63:0] second_value;
        t_status            status;
    } t_point;

    // bit position of the payload of continuation byte n (n >= 1): 6 + 7*(n-1)
    function automatic logic [5:0] payload_shift(input logic [3:0] n);
        logic [6:0] t;
        t = 7'(n) * 7'd7 - 7'd1;
        return t[5:0];
    endfunction

endpackage

[hw/rtl/svdc_in_if.sv]
// byte channel of the signed varint delta coordinate decoder
// depends on nothing
`timescale 1ns / 1ps

interface svdc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_array;

    modport source (output valid, output data_byte, output start_array, input ready);
    modport sink   (input valid, input data_byte, input start_array, output ready);
endinterface

[hw/rtl/svdc_out_if.sv]
// point channel of the signed varint delta coordinate decoder
// depends on nothing
`timescale 1ns / 1ps

interface svdc_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] first_value;
    logic signed [63:0] second_value;
    logic [1:0]         status;

    modport source (output valid, output first_value, output second_value, output status,
                    input ready);
    modport sink   (input valid, input first_value, input second_value, input status,
                    output ready);
endinterface

[hw/rtl/signed_varint_delta_coord_decoder.sv]
// Signed varint delta coordinate decoder. One byte is taken per transaction and the
// block takes a new byte in every clock cycle unless the output is stalled; a point
// passes from the input register through decode and accumulate into the output
// register, where it waits to be taken. The decode stage does a 63-bit payload insert
// and one 64-bit add with overflow check per byte. The output register lets the next
// byte enter while a finished point waits to be taken; with the output stalled the
// input register holds one more byte. Write ordinates_per_point only while idle.
// depends on svdc_pkg, svdc_in_if, svdc_out_if, svdc_varint, svdc_accum
`timescale 1ns / 1ps

module signed_varint_delta_coord_decoder
    import svdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,
    svdc_in_if.sink     i_byte_ch,
    svdc_out_if.source  o_point_ch
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;
    logic [1:0] r_opp;
    t_point     r_out;

    logic       proceed;
    logic       in_accept;
    logic       err_hold;
    t_vint_res  vint;
    t_point     point;

    assign proceed   = r_in_valid && (!r_out.valid || o_point_ch.ready);
    assign in_accept = i_byte_ch.valid && i_byte_ch.ready;
    assign i_byte_ch.ready = !r_in_valid || proceed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (proceed) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte  <= i_byte_ch.data_byte;
            r_in_start <= i_byte_ch.start_array;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opp <= OPP_RESET;
        end else if (i_cfg_wr_en) begin
            r_opp <= i_cfg_wr_data;
        end
    end

    svdc_varint u_varint (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (proceed),
        .i_byte     (r_in_byte),
        .i_start    (r_in_start),
        .i_err_hold (err_hold),
        .o_res      (vint)
    );

    svdc_accum u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (proceed),
        .i_start       (r_in_start),
        .i_single      (r_opp == OPP_SINGLE),
        .i_cfg_clr_sel (i_cfg_wr_en && (i_cfg_wr_data == OPP_SINGLE)),
        .i_vint        (vint),
        .o_err_hold    (err_hold),
        .o_point       (point)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (proceed && point.valid) begin
            r_out.valid <= 1'b1;
        end else if (o_point_ch.ready) begin
            r_out.valid <= 1'b0;
        end
        if (proceed && point.valid) begin
            r_out.first_value  <= point.first_value;
            r_out.second_value <= point.second_value;
            r_out.status       <= point.status;
        end
    end

    assign o_point_ch.valid        = r_out.valid;
    assign o_point_ch.first_value  = r_out.first_value;
    assign o_point_ch.second_value = r_out.second_value;
    assign o_point_ch.status       = r_out.status;

    a_point_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proceed && point.valid) |=> r_out.valid)
        else $error("decoded point not captured in output register");

endmodule

[hw/rtl/svdc_varint.sv]
// varint decoder stage: sign, magnitude and byte count of the value in flight
// depends on svdc_pkg
`timescale 1ns / 1ps

module svdc_varint
    import svdc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    input  logic       i_start,
    input  logic       i_err_hold,
    output t_vint_res  o_res
);

    logic [62:0] r_mag,   n_mag;
    logic [3:0]  r_bytes, n_bytes;
    logic        r_sign,  n_sign;

    logic [62:0] base_mag;
    logic [3:0]  base_bytes;
    logic        base_sign;
    logic        active;
    logic [62:0] ins;
    logic [62:0] merged;
    logic        last;

    always_comb begin
        base_mag   = i_start ? '0 : r_mag;
        base_bytes = i_start ? '0 : r_bytes;
        base_sign  = i_start ? 1'b0 : r_sign;
        active     = i_en && !(i_err_hold && !i_start);
        ins        = {56'b0, i_byte[6:0]} << payload_shift(base_bytes);
        merged     = base_mag | ins;
        last       = (base_bytes == LAST_BYTE);

        n_mag   = i_en ? base_mag   : r_mag;
        n_bytes = i_en ? base_bytes : r_bytes;
        n_sign  = i_en ? base_sign  : r_sign;
        o_res   = '0;

        if (active) begin
            if (base_bytes == 4'd0) begin
                n_sign = i_byte[6];
                if (i_byte[7]) begin
                    n_mag   = {57'b0, i_byte[5:0]};
                    n_bytes = 4'd1;
                end else begin
                    o_res.done = 1'b1;
                    o_res.neg  = i_byte[6];
                    o_res.mag  = {57'b0, i_byte[5:0]};
                    n_mag      = '0;
                    n_sign     = 1'b0;
                end
            end else if (last && (i_byte[7] || (i_byte[6:1] != 6'd0))) begin
                // too long, or magnitude beyond 63 bits
                o_res.bad = 1'b1;
                n_mag     = '0;
                n_bytes   = '0;
                n_sign    = 1'b0;
            end else if (i_byte[7]) begin
                n_mag   = merged;
                n_bytes = base_bytes + 4'd1;
            end else begin
                o_res.done = 1'b1;
                o_res.neg  = base_sign;
                o_res.mag  = merged;
                n_mag      = '0;
                n_bytes    = '0;
                n_sign     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag   <= '0;
            r_bytes <= '0;
            r_sign  <= 1'b0;
        end else begin
            r_mag   <= n_mag;
            r_bytes <= n_bytes;
            r_sign  <= n_sign;
        end
    end

    a_bytes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes <= LAST_BYTE)
        else $error("byte count past the last allowed byte");

endmodule

[hw/rtl/svdc_accum.sv]
// accumulate stage: running sums, ordinate select, error hold, result forming
// depends on svdc_pkg
`timescale 1ns / 1ps

module svdc_accum
    import svdc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_start,
    input  logic      i_single,
    input  logic      i_cfg_clr_sel,
    input  t_vint_res i_vint,
    output logic      o_err_hold,
    output t_point    o_point
);

    logic [63:0] r_sum1, n_sum1;
    logic [63:0] r_sum2, n_sum2;
    logic        r_sel,  n_sel;
    logic        r_err,  n_err;

    logic [63:0] base_sum1;
    logic [63:0] base_sum2;
    logic        base_sel;
    logic        second;
    logic [63:0] op_a;
    logic [63:0] mag64;
    logic [63:0] addend;
    logic [63:0] sum_res;
    logic        delta_neg;
    logic        ovf;

    always_comb begin
        base_sum1 = i_start ? '0 : r_sum1;
        base_sum2 = i_start ? '0 : r_sum2;
        base_sel  = i_start ? 1'b0 : r_sel;

        // sum - mag is sum + ~mag + 1, one adder with carry-in
        second    = !i_single && base_sel;
        op_a      = second ? base_sum2 : base_sum1;
        mag64     = {1'b0, i_vint.mag};
        addend    = i_vint.neg ? ~mag64 : mag64;
        sum_res   = op_a + addend + {63'b0, i_vint.neg};
        delta_neg = i_vint.neg && (i_vint.mag != 63'd0);
        ovf       = (op_a[63] == delta_neg) && (sum_res[63] != op_a[63]);

        n_sum1  = i_en ? base_sum1 : r_sum1;
        n_sum2  = i_en ? base_sum2 : r_sum2;
        n_sel   = i_en ? base_sel  : r_sel;
        n_err   = i_en ? (r_err && !i_start) : r_err;
        o_point = '0;

        if (i_en && i_vint.bad) begin
            n_err          = 1'b1;
            o_point.valid  = 1'b1;
            o_point.status = ST_BAD_VARINT;
        end else if (i_en && i_vint.done) begin
            if (ovf) begin
                n_err          = 1'b1;
                o_point.valid  = 1'b1;
                o_point.status = ST_SUM_OVF;
            end else if (i_single) begin
                n_sum1               = sum_res;
                o_point.valid        = 1'b1;
                o_point.first_value  = sum_res;
                o_point.status       = ST_OK;
            end else if (!base_sel) begin
                n_sum1 = sum_res;
                n_sel  = 1'b1;
            end else begin
                n_sum2               = sum_res;
                n_sel                = 1'b0;
                o_point.valid        = 1'b1;
                o_point.first_value  = base_sum1;
                o_point.second_value = sum_res;
                o_point.status       = ST_OK;
            end
        end

        if (i_cfg_clr_sel) begin
            n_sel = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum1 <= '0;
            r_sum2 <= '0;
            r_sel  <= 1'b0;
            r_err  <= 1'b0;
        end else begin
            r_sum1 <= n_sum1;
            r_sum2 <= n_sum2;
            r_sel  <= n_sel;
            r_err  <= n_err;
        end
    end

    assign o_err_hold = r_err;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_point.valid && o_point.status != ST_OK) |->
            (o_point.first_value == 64'sd0 && o_point.second_value == 64'sd0))
        else $error("error result carries nonzero values");

    a_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err && !i_start) |-> !o_point.valid)
        else $error("result produced while an error is held");

endmodule

[sim/signed_varint_delta_coord_decoder_tb.sv]
// self-checking bench for signed_varint_delta_coord_decoder: a directed table, then
// randomized coordinate arrays, checked against a cycle-free predictor of the decoder
// depends on svdc_pkg, svdc_in_if, svdc_out_if and the decoder rtl
`timescale 1ns / 1ps

module signed_varint_delta_coord_decoder_tb
    import svdc_pkg::*;
();

    localparam logic [63:0] MAG_LIMIT     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [1:0]  OPP_PAIR_LO   = 2'd0;
    localparam logic [1:0]  OPP_PAIR_HI   = 2'd3;
    localparam int          STALL_LIMIT   = 400;
    localparam int          DRAIN_LIMIT   = 200;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          PHASES        = 8;
    localparam int          PHASE_ITEMS   = 250;

    typedef struct {
        logic [63:0] first_value;
        logic [63:0] second_value;
        t_status     status;
    } t_coord_pt;

    typedef enum {ROW_BYTE, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [7:0]  data;
        logic        start;
        bit          typed;
        bit          has_point;
        t_coord_pt   point;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [1:0] i_cfg_wr_data;

    svdc_in_if  byte_ch();
    svdc_out_if point_ch();

    signed_varint_delta_coord_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_byte_ch     (byte_ch),
        .o_point_ch    (point_ch)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    logic [1:0]  ords;
    logic [63:0] acc_mag;
    int          run_len;
    logic        neg_flag;
    logic        y_pending;
    logic [63:0] sum_x;
    logic [63:0] sum_y;
    logic        err_latched;

    t_coord_pt   expected_points[$];
    t_coord_pt   oldest_point;
    t_stim_row   plan[$];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          live_items;
    bit          in_calm = 1'b0;
    bit          out_calm = 1'b0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    function automatic bit add_overflows(input logic [63:0] a, input logic [63:0] d);
        logic [63:0] r;
        r = a + d;
        return (a[63] == d[63]) && (r[63] != a[63]);
    endfunction

    function automatic t_coord_pt error_point(input t_status st);
        t_coord_pt pt;
        err_latched = 1'b1;
        acc_mag     = '0;
        run_len     = 0;
        neg_flag    = 1'b0;
        pt.first_value  = '0;
        pt.second_value = '0;
        pt.status       = st;
        return pt;
    endfunction

    // one byte through the decoder; returns 1 when a point or an error comes out
    function automatic bit decode_byte(input logic [7:0] b, input logic st,
                                       output t_coord_pt pt, output bit ignored);
        logic [63:0] payload;
        logic [63:0] delta;
        int          shift;
        pt.first_value  = '0;
        pt.second_value = '0;
        pt.status       = ST_OK;
        ignored = 1'b0;
        if (st) begin
            acc_mag     = '0;
            run_len     = 0;
            neg_flag    = 1'b0;
            y_pending   = 1'b0;
            sum_x       = '0;
            sum_y       = '0;
            err_latched = 1'b0;
        end
        if (err_latched) begin
            ignored = 1'b1;
            return 1'b0;
        end
        if (run_len == 0) begin
            neg_flag = b[6];
            acc_mag  = {58'd0, b[5:0]};
            if (b[7]) begin
                run_len = 1;
                return 1'b0;
            end
        end else begin
            shift   = 6 + 7 * (run_len - 1);
            payload = {57'd0, b[6:0]};
            if (run_len >= MAX_BYTES || payload > (MAG_LIMIT >> shift)) begin
                pt = error_point(ST_BAD_VARINT);
                return 1'b1;
            end
            acc_mag |= payload << shift;
            if (b[7]) begin
                if (run_len + 1 >= MAX_BYTES) begin
                    pt = error_point(ST_BAD_VARINT);
                    return 1'b1;
                end
                run_len++;
                return 1'b0;
            end
        end
        acc_mag &= MAG_LIMIT;
        delta    = neg_flag ? -acc_mag : acc_mag;
        acc_mag  = '0;
        run_len  = 0;
        neg_flag = 1'b0;
        if (ords == OPP_SINGLE || !y_pending) begin
            if (add_overflows(sum_x, delta)) begin
                pt = error_point(ST_SUM_OVF);
                return 1'b1;
            end
            sum_x += delta;
            if (ords == OPP_SINGLE) begin
                pt.first_value = sum_x;
                return 1'b1;
            end
            y_pending = 1'b1;
            return 1'b0;
        end
        if (add_overflows(sum_y, delta)) begin
            pt = error_point(ST_SUM_OVF);
            return 1'b1;
        end
        sum_y += delta;
        y_pending = 1'b0;
        pt.first_value  = sum_x;
        pt.second_value = sum_y;
        return 1'b1;
    endfunction

    // called and returning at a falling edge; valid stays up for back-to-back bytes
    task automatic push_byte(input logic [7:0] b, input logic st, input bit predicted);
        int        gap;
        t_coord_pt pt;
        bit        has_point;
        bit        ignored;
        gap = in_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.data_byte   <= b;
        byte_ch.start_array <= st;
        do @(posedge i_clk); while (!byte_ch.ready);
        has_point = decode_byte(b, st, pt, ignored);
        if (!ignored) live_items++;
        if (has_point && predicted) expected_points.insert(expected_points.size(), pt);
        @(negedge i_clk);
    endtask

    // hold the sender until every point is out, then let the pipeline empty
    task automatic wait_idle;
        int waited;
        waited = 0;
        byte_ch.valid <= 1'b0;
        while (expected_points.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_ordinates(input logic [1:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        ords = v;
        if (v == OPP_SINGLE) y_pending = 1'b0;
    endtask

    task automatic add_row(input t_row_kind kind, input logic [7:0] data, input logic start,
                           input bit typed, input bit has_point, input logic [63:0] fv,
                           input logic [63:0] sv, input t_status st);
        t_stim_row r;
        r.kind               = kind;
        r.data               = data;
        r.start              = start;
        r.typed              = typed;
        r.has_point          = has_point;
        r.point.first_value  = fv;
        r.point.second_value = sv;
        r.point.status       = st;
        plan.insert(plan.size(), r);
    endtask

    // one varint; a cut value stops early so the next start lands mid-value
    task automatic send_value(input bit opens_array, input bit cut);
        int         len;
        int         stop;
        int         pick;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 55)      len = 1;
        else if (pick < 75) len = $urandom_range(2, 3);
        else if (pick < 87) len = $urandom_range(4, 8);
        else                len = $urandom_range(9, 10);
        stop = (cut && len > 1) ? $urandom_range(1, len - 1) : len;
        for (int k = 0; k < stop; k++) begin
            b = 8'($urandom_range(0, 255));
            b[7] = (k < len - 1);
            if (k == 9) begin
                // last legal byte: payload of 1 reaches bit 62, more is out of range
                pick = $urandom_range(0, 9);
                b[6:0] = (pick < 5) ? 7'd1 : (pick < 7) ? 7'd0 : 7'($urandom_range(2, 127));
                b[7]   = ($urandom_range(0, 4) == 0);
            end
            push_byte(b, opens_array && k == 0, 1'b1);
        end
    endtask

    task automatic send_array;
        int nvals;
        in_calm = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 8))
                push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b1);
        end else begin
            nvals = $urandom_range(1, 12);
            for (int i = 0; i < nvals; i++)
                send_value(i == 0, i == nvals - 1 && $urandom_range(0, 9) == 0);
        end
    endtask

    // output checker
    always @(posedge i_clk) begin
        if (i_rst_n && point_ch.valid && point_ch.ready) begin
            if (expected_points.size() == 0) begin
                report_mismatch("point with none expected", point_ch.first_value,
                                point_ch.second_value);
            end else begin
                oldest_point = expected_points.pop_front();
                if (point_ch.first_value !== oldest_point.first_value)
                    report_mismatch("first_value", point_ch.first_value,
                                    oldest_point.first_value);
                if (point_ch.second_value !== oldest_point.second_value)
                    report_mismatch("second_value", point_ch.second_value,
                                    oldest_point.second_value);
                if (point_ch.status !== oldest_point.status)
                    report_mismatch("status", 64'(point_ch.status),
                                    64'(oldest_point.status));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (point_ch.valid && point_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // point receiver with random back-pressure
    initial begin
        int gap;
        point_ch.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
            gap = out_calm ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                point_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            point_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!point_ch.valid);
            @(negedge i_clk);
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_wr_en         = 1'b0;
        i_cfg_wr_data       = '0;
        byte_ch.valid       = 1'b0;
        byte_ch.data_byte   = '0;
        byte_ch.start_array = 1'b0;

        ords        = OPP_RESET;
        acc_mag     = '0;
        run_len     = 0;
        neg_flag    = 1'b0;
        y_pending   = 1'b0;
        sum_x       = '0;
        sum_y       = '0;
        err_latched = 1'b0;
        live_items  = 0;

        // pair mode out of reset: zeros, a negative x with negative-zero y
        add_row(ROW_BYTE, 8'h00, 1'b1, 1'b0, 1'b0, '0, '0, ST_OK);
        add_row(ROW_BYTE, 8'h00, 1'b0, 1'b1, 1'b1, '0, '0, ST_OK);
        add_row(ROW_BYTE, 8'h41, 1'b0, 1'b0, 1'b0, '0, '0, ST_OK);
        add_row(ROW_BYTE, 8'h40, 1'b0, 1'b1, 1'b1, '1, '0, ST_OK);
        // ten-byte x of full magnitude, then x overflow and an ignored byte
        add_row(ROW_BYTE, 8'hBF, 1'b1, 1'b0, 1'b0, '0, '0, ST_OK);
        repeat (8) add_row(ROW_BYTE, 8'hFF, 1'b0, 1'b0, 1'b0, '0, '0, ST_OK);
        add_row(ROW_BYTE, 8'h01, 1'b0, 1'b0, 1'b0, '0, '0, ST_OK);
        add_row(ROW_BYTE, 8'h3F, 1'b0, 1'b1, 1'b1, MAG_LIMIT, 64'd63, ST_OK);
        add_row(ROW_BYTE, 8'h01, 1'b0, 1'b1, 1'b1, '0, '0, ST_SUM_OVF);
        add_row(ROW_BYTE, 8'h7F, 1'b0, 1'b1, 1'b0, '0, '0, ST_OK);
        // single mode: magnitude beyond 63 bits on the tenth byte, then plain values
        add_row(ROW_CFG, 8'(OPP_SINGLE), 1'b0, 1'b0, 1'b0, '0, '0, ST_OK);
        add_row(ROW_BYTE, 8'hFF, 1'b1, 1'b0, 1'b0, '0, '0, ST_OK);
        repeat (8) add_row(ROW_BYTE, 8'hFF, 1'b0, 1'b0, 1'b0, '0, '0, ST_OK);
        add_row(ROW_BYTE, 8'h02, 1'b0, 1'b1, 1'b1, '0, '0, ST_BAD_VARINT);
        add_row(ROW_BYTE, 8'h05, 1'b1, 1'b1, 1'b1, 64'd5, '0, ST_OK);
        add_row(ROW_BYTE, 8'h45, 1'b0, 1'b1, 1'b1, '0, '0, ST_OK);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                wait_idle();
                write_ordinates(plan[i].data[1:0]);
            end else begin
                if (plan[i].typed && plan[i].has_point)
                    expected_points.insert(expected_points.size(), plan[i].point);
                push_byte(plan[i].data, plan[i].start, !plan[i].typed);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            case (phase % 4)
                0:       write_ordinates(OPP_SINGLE);
                1:       write_ordinates(OPP_PAIR_LO);
                2:       write_ordinates(OPP_PAIR_HI);
                default: write_ordinates(OPP_RESET);
            endcase
            live_items = 0;
            while (live_items < PHASE_ITEMS) send_array();
        end

        wait_idle();
        if (expected_points.size() != 0)
            report_mismatch("points never delivered", 64'(expected_points.size()), '0);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
